FILE: hw/rtl/first_fit_range_allocator_macros.svh
// Assertion macros for the first-fit range allocator checker.
// Included by the checker file; depends on nothing else.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define FFRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define FFRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator.
// No dependencies.
package ffra_pkg;
  localparam int MaxRanges = 16;
  localparam int AddrBits  = 32;
  localparam int IdxBits   = $clog2(MaxRanges);
  localparam int CntBits   = $clog2(MaxRanges + 1);
  localparam logic [31:0] SpaceReset = 32'd65536;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_ZERO    = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } state_t;

  // Datapath actions chosen by the controller.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ALLOC_SHRINK,
    ACT_REMOVE,
    ACT_JOIN_PREV,
    ACT_JOIN_NEXT,
    ACT_JOIN_BOTH,
    ACT_INSERT
  } act_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_step;
    logic apply;
    act_t act;
    logic shift_step;
    logic shift_dir_up;
    logic res_load;
    logic res_ok;
    status_t res_status;
  } ctrl_t;

  typedef struct packed {
    func_t func;
    logic  size_zero;
    logic  scan_end;
    logic  hit;
    logic  exact;
    logic  joinp;
    logic  joinn;
    logic  full;
    logic  shift_up;
    logic  shift_end;
  } stat_t;
endpackage

FILE: hw/rtl/ffra_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on ffra_pkg.
interface ffra_req_if import ffra_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] req_size;
  logic [31:0] req_offset;
  modport source (output valid, func, req_size, req_offset, input ready);
  modport sink   (input valid, func, req_size, req_offset, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        ok;
  logic [1:0]  status;
  logic [31:0] grant_offset;
  logic [31:0] free_total;
  modport source (output valid, ok, status, grant_offset, free_total, input ready);
  modport sink   (input valid, ok, status, grant_offset, free_total, output ready);
endinterface

interface ffra_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/ffra_ctrl.sv
// Controller state machine for the allocator.
// Depends on ffra_pkg.
module ffra_ctrl import ffra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output ctrl_t ctl
);
  state_t state_r, state_nxt;

  // Hold the state.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequence each operation: scan, decide, shift, deliver; steps run only as needed.
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.act = ACT_NONE;
    ctl.res_status = ST_OK;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.func == FUNC_CLEAR) begin
          ctl.clear = 1'b1;
          ctl.res_load = 1'b1;
          ctl.res_ok = 1'b1;
          state_nxt = S_DONE;
        end else if (st.func == FUNC_NONE) begin
          ctl.res_load = 1'b1;
          state_nxt = S_DONE;
        end else if (st.func == FUNC_FREE && st.size_zero) begin
          ctl.res_load = 1'b1;
          ctl.res_status = ST_ZERO;
          state_nxt = S_DONE;
        end else if (st.scan_end || st.hit) begin
          state_nxt = S_DECIDE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_DECIDE: begin
        ctl.res_load = 1'b1;
        ctl.apply = 1'b1;
        ctl.res_ok = 1'b1;
        state_nxt = S_DONE;
        if (st.func == FUNC_ALLOC) begin
          if (!st.hit) begin
            ctl.apply = 1'b0;
            ctl.res_ok = 1'b0;
            ctl.res_status = ST_NO_FIT;
          end else if (st.exact) begin
            ctl.act = ACT_REMOVE;
            ctl.shift_dir_up = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            ctl.act = ACT_ALLOC_SHRINK;
          end
        end else begin
          if (st.joinp && st.joinn) begin
            ctl.act = ACT_JOIN_BOTH;
            state_nxt = S_SHIFT;
          end else if (st.joinp) begin
            ctl.act = ACT_JOIN_PREV;
          end else if (st.joinn) begin
            ctl.act = ACT_JOIN_NEXT;
          end else if (st.full) begin
            ctl.apply = 1'b0;
            ctl.res_ok = 1'b0;
            ctl.res_status = ST_FULL;
          end else begin
            ctl.act = ACT_INSERT;
            ctl.shift_dir_up = 1'b1;
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ctl.shift_dir_up = st.shift_up;
        if (st.shift_end) state_nxt = S_DONE;
        else              ctl.shift_step = 1'b1;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/ffra_dp.sv
// Datapath of the allocator: range table, scan pointer, shifter, result.
// Depends on ffra_pkg.
module ffra_dp import ffra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_req_offset,
  input  ctrl_t       ctl,
  output stat_t       st,
  output logic        res_ok,
  output logic [1:0]  res_status,
  output logic [31:0] res_grant,
  output logic [31:0] res_total
);
  addr_t start_r [MaxRanges];
  addr_t len_r   [MaxRanges];
  cnt_t  count_r;
  addr_t sum_r;
  logic [31:0] space_r;
  func_t func_r;
  addr_t size_r, off_r;
  cnt_t  ptr_r;   // scan position p
  cnt_t  sh_r;    // shift position
  logic  hit_r;
  logic  joinp_r, joinn_r;
  logic  sh_valid_r;
  logic  ok_r;
  status_t status_r;
  addr_t grant_r;

  idx_t  pi, pmi, shi;
  logic  at_end;
  addr_t cur_s, cur_l, prv_s, prv_l;
  logic  fits;

  assign pi  = ptr_r[IdxBits-1:0];
  assign pmi = IdxBits'(ptr_r - 1'b1);
  assign shi = sh_r[IdxBits-1:0];
  assign at_end = (ptr_r >= count_r) || (ptr_r == cnt_t'(MaxRanges));
  assign cur_s = start_r[pi];
  assign cur_l = len_r[pi];
  assign prv_s = start_r[pmi];
  assign prv_l = len_r[pmi];
  assign fits = (func_r == FUNC_ALLOC) ? (cur_l >= size_r) : !(cur_s < off_r);

  // Status to the controller.
  always_comb begin
    st.func      = func_r;
    st.size_zero = (size_r == '0);
    st.scan_end  = at_end;
    st.hit       = !at_end && fits;
    st.exact     = (cur_l == size_r);
    st.joinp     = (ptr_r != '0) && ((prv_s + prv_l) == off_r);
    st.joinn     = !at_end && ((off_r + size_r) == cur_s);
    st.full      = (count_r >= cnt_t'(MaxRanges));
    st.shift_up  = (func_r == FUNC_FREE) && !(joinp_r && joinn_r);
    if (st.shift_up)
      st.shift_end = (sh_r <= ptr_r);
    else
      st.shift_end = (sh_r + 1'b1 >= count_r);
  end

  // Hold config register.
  always_ff @(posedge clk) begin
    if (!rst_n)      space_r <= SpaceReset;
    else if (cfg_we) space_r <= cfg_data;
  end

  // Request capture, scan pointer, shift and table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= cnt_t'(1);
      sum_r <= addr_t'(SpaceReset);
      start_r[0] <= '0;
      len_r[0] <= addr_t'(SpaceReset);
    end else begin
      if (ctl.load) begin
        func_r <= func_t'(in_func);
        size_r <= addr_t'(in_req_size);
        off_r  <= addr_t'(in_req_offset);
        ptr_r  <= '0;
      end
      if (ctl.scan_step) ptr_r <= ptr_r + 1'b1;
      if (ctl.clear) begin
        start_r[0] <= '0;
        len_r[0] <= addr_t'(space_r);
        count_r <= (space_r != '0) ? cnt_t'(1) : '0;
        sum_r <= addr_t'(space_r);
      end
      if (ctl.apply) begin
        joinp_r <= st.joinp;
        joinn_r <= st.joinn;
        unique case (ctl.act)
          ACT_ALLOC_SHRINK: begin
            start_r[pi] <= cur_s + size_r;
            len_r[pi] <= cur_l - size_r;
            sum_r <= sum_r - size_r;
          end
          ACT_REMOVE: begin
            sh_r <= ptr_r;
            sum_r <= sum_r - size_r;
          end
          ACT_JOIN_PREV: begin
            len_r[pmi] <= prv_l + size_r;
            sum_r <= sum_r + size_r;
          end
          ACT_JOIN_NEXT: begin
            start_r[pi] <= off_r;
            len_r[pi] <= cur_l + size_r;
            sum_r <= sum_r + size_r;
          end
          ACT_JOIN_BOTH: begin
            len_r[pmi] <= prv_l + size_r + cur_l;
            sh_r <= ptr_r;
            sum_r <= sum_r + size_r;
          end
          ACT_INSERT: begin
            sh_r <= count_r;
            sum_r <= sum_r + size_r;
          end
          default: ;
        endcase
      end
      // Shift one entry a cycle; finish with count update and the insert.
      if (ctl.shift_step) begin
        if (ctl.shift_dir_up) begin
          start_r[shi] <= start_r[IdxBits'(sh_r - 1'b1)];
          len_r[shi] <= len_r[IdxBits'(sh_r - 1'b1)];
          sh_r <= sh_r - 1'b1;
        end else begin
          start_r[shi] <= start_r[IdxBits'(sh_r + 1'b1)];
          len_r[shi] <= len_r[IdxBits'(sh_r + 1'b1)];
          sh_r <= sh_r + 1'b1;
        end
      end
      if (!ctl.shift_step && !ctl.apply && !ctl.load && !ctl.clear
          && st.shift_end && sh_valid_r) begin
        if (st.shift_up) begin
          start_r[pi] <= off_r;
          len_r[pi] <= size_r;
          count_r <= count_r + 1'b1;
        end else begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  // Track that a shift is under way.
  always_ff @(posedge clk) begin
    if (!rst_n) sh_valid_r <= 1'b0;
    else if (ctl.apply)
      sh_valid_r <= (ctl.act == ACT_REMOVE) || (ctl.act == ACT_JOIN_BOTH)
                    || (ctl.act == ACT_INSERT);
    else if (!ctl.shift_step && st.shift_end) sh_valid_r <= 1'b0;
  end

  // Capture the result fields.
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      ok_r <= ctl.res_ok;
      status_r <= ctl.res_status;
      grant_r <= (func_r == FUNC_ALLOC && ctl.res_ok) ? cur_s : '0;
    end
  end

  assign res_ok = ok_r;
  assign res_status = status_r;
  assign res_grant = grant_r[31:0];
  assign res_total = sum_r[31:0];
endmodule

FILE: hw/rtl/first_fit_range_allocator.sv
// First-fit range allocator: one operation at a time. After the input
// transfer an operation scans the table entry by entry until a hit or the
// end, then decides and, for a removal or insertion, shifts the moved
// entries and closes with the count update. A clear, a no-op or a
// zero-size free goes straight from the scan to the result.
// The result is held in the output register until taken.
// Depends on ffra_pkg, ffra_if, ffra_ctrl, ffra_dp.
module first_fit_range_allocator import ffra_pkg::*; (
  input logic clk,
  input logic rst_n,
  ffra_req_if.sink   in_ch,
  ffra_rsp_if.source out_ch,
  ffra_cfg_if.sink   cfg_ch
);
  ctrl_t ctl;
  stat_t st;

  assign cfg_ch.ready = 1'b1;

  ffra_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st, .ctl
  );

  ffra_dp u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .in_func(in_ch.func), .in_req_size(in_ch.req_size),
    .in_req_offset(in_ch.req_offset),
    .ctl, .st,
    .res_ok(out_ch.ok), .res_status(out_ch.status),
    .res_grant(out_ch.grant_offset), .res_total(out_ch.free_total)
  );
endmodule

FILE: hw/rtl/ffra_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on the macros header.
`include "first_fit_range_allocator_macros.svh"
module ffra_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_ok,
  input logic [1:0] out_status,
  input logic [31:0] out_grant
);
  `FFRA_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `FFRA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `FFRA_ASSERT_IMP(a_fail_grant, clk, rst_n, out_valid && !out_ok, out_grant == 32'd0)
  `FFRA_ASSERT_IMP(a_ok_status, clk, rst_n, out_valid && out_ok, out_status == 2'd0)
  `FFRA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind first_fit_range_allocator ffra_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_ok(out_ch.ok), .out_status(out_ch.status), .out_grant(out_ch.grant_offset)
);
